// ----- hdl/spm_pkg.sv -----
// shared types and constants for the stream pattern matcher
package spm_pkg;

  localparam int LEN_W       = 4;
  localparam int PAT_BYTES   = 8;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 8;
  localparam int MATCH_W     = 16;
  localparam int BYTE_W      = 8;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES  = CFG_IDX_W'(1);

  localparam logic [LEN_W-1:0]      PATTERN_LENGTH_RESET = LEN_W'(1);
  localparam logic [CFG_DATA_W-1:0] PATTERN_BYTES_RESET  = '0;

  typedef struct packed {
    logic               push;
    logic [MATCH_W-1:0] match_start;
  } spm_push_t;

endpackage

// ----- hdl/spm_front.sv -----
// front end: takes text bytes, keeps the window and count, flags matches
module spm_front import spm_pkg::*; #(
  parameter int PATTERN_MAX = 8,
  parameter int TEXT_MAX    = 65536
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [BYTE_W-1:0]     text_byte,
  input  logic                  text_start,
  input  logic [LEN_W-1:0]      pattern_length,
  input  logic [CFG_DATA_W-1:0] pattern_bytes,
  input  logic                  queue_full,
  output spm_push_t             push
);

  localparam int LW = $clog2(PATTERN_MAX + 1);
  localparam int IW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
  localparam int CW = $clog2(TEXT_MAX + 1);

  logic [BYTE_W-1:0] window [PATTERN_MAX];
  logic [BYTE_W-1:0] window_next [PATTERN_MAX];
  logic [BYTE_W-1:0] pat_arr [PATTERN_MAX];
  logic [CW-1:0]     seen;
  logic [CW-1:0]     seen_base;
  logic [CW-1:0]     seen_plus;
  logic [LW-1:0]     eff_len;
  logic [IW-1:0]     pat_idx;
  logic [31:0]       start_diff;
  logic              accept;
  logic              saturated;
  logic              too_short;
  logic              hit;

  // pattern bytes beyond the packed register compare against zero
  for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_pat
    if (j < PAT_BYTES) begin : g_in
      assign pat_arr[j] = pattern_bytes[BYTE_W*j +: BYTE_W];
    end else begin : g_zero
      assign pat_arr[j] = '0;
    end
  end

  assign in_stall = queue_full;
  assign accept   = in_valid & ~queue_full;

  always_comb begin
    if (pattern_length == '0) begin
      eff_len = LW'(1);
    end else if (int'(pattern_length) > PATTERN_MAX) begin
      eff_len = LW'(PATTERN_MAX);
    end else begin
      eff_len = LW'(pattern_length);
    end
  end

  always_comb begin
    seen_base = text_start ? '0 : seen;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (i == 0) begin
        window_next[i] = text_byte;
      end else begin
        window_next[i] = text_start ? '0 : window[i-1];
      end
    end
    saturated  = seen_base >= CW'(TEXT_MAX);
    seen_plus  = seen_base + CW'(1);
    too_short  = 32'(seen_plus) < 32'(eff_len);
    start_diff = 32'(seen_plus) - 32'(eff_len);
    // newest byte sits in slot 0 and lines up with the last pattern byte
    hit     = 1'b1;
    pat_idx = '0;
    for (int i = 0; i < PATTERN_MAX; i++) begin
      if (LW'(i) < eff_len) begin
        pat_idx = IW'(eff_len - LW'(1) - LW'(i));
        if (window_next[i] != pat_arr[pat_idx]) begin
          hit = 1'b0;
        end
      end
    end
    push.push        = accept & ~saturated & ~too_short & hit;
    push.match_start = start_diff[MATCH_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
      for (int i = 0; i < PATTERN_MAX; i++) begin
        window[i] <= '0;
      end
    end else if (accept) begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
        window[i] <= window_next[i];
      end
      seen <= saturated ? seen_base : seen_plus;
    end
  end

endmodule

// ----- hdl/spm_queue.sv -----
// back end: short queue of match positions feeding the output channel
module spm_queue import spm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  spm_push_t          push,
  output logic               queue_full,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [MATCH_W-1:0] match_start
);

  localparam int QPW = $clog2(QUEUE_DEPTH);
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  logic [MATCH_W-1:0] mem [QUEUE_DEPTH];
  logic [QPW-1:0]     wr_ptr;
  logic [QPW-1:0]     rd_ptr;
  logic [QCW-1:0]     count;
  logic               pop;

  assign queue_full  = count == QCW'(QUEUE_DEPTH);
  assign out_valid   = count != '0;
  assign match_start = mem[rd_ptr];
  assign pop         = out_valid & ~out_stall;

  always_ff @(posedge clk) begin
    if (push.push) begin
      mem[wr_ptr] <= push.match_start;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.push) begin
        wr_ptr <= wr_ptr + QPW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + QPW'(1);
      end
      if (push.push && !pop) begin
        count <= count + QCW'(1);
      end else if (pop && !push.push) begin
        count <= count - QCW'(1);
      end
    end
  end

endmodule

// ----- hdl/stream_pattern_match_positions_top.sv -----
// stream pattern matcher: window compare front end, match queue back end
// a match enters the queue when its last byte is taken; out_valid follows the registered queue count
// throughput: one text byte per cycle while in_stall is low; the window compare is combinational
// in_stall rises only while the four-entry match queue is full
// reset clears window, byte count and queue; pattern_length goes to 1, pattern to 0
module stream_pattern_match_positions_top import spm_pkg::*; #(
  parameter int PATTERN_MAX = 8,
  parameter int TEXT_MAX    = 65536
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [BYTE_W-1:0]     text_byte,
  input  logic                  text_start,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [MATCH_W-1:0]    match_start,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [LEN_W-1:0]      pattern_length;
  logic [CFG_DATA_W-1:0] pattern_bytes;
  logic                  queue_full;
  spm_push_t             push;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= PATTERN_LENGTH_RESET;
      pattern_bytes  <= PATTERN_BYTES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        CFG_PATTERN_BYTES:  pattern_bytes  <= cfg_data;
        default: ;
      endcase
    end
  end

  spm_front #(
    .PATTERN_MAX(PATTERN_MAX),
    .TEXT_MAX   (TEXT_MAX)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .text_byte     (text_byte),
    .text_start    (text_start),
    .pattern_length(pattern_length),
    .pattern_bytes (pattern_bytes),
    .queue_full    (queue_full),
    .push          (push)
  );

  spm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .queue_full (queue_full),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .match_start(match_start)
  );

endmodule
